### hdl/line_table_delta_encoder_assert.svh
// Assertion macros for the line table delta encoder checker.
// Needs a clk and an active-low arst_n in the scope of each use.
`ifndef LINE_TABLE_DELTA_ENCODER_ASSERT_SVH
`define LINE_TABLE_DELTA_ENCODER_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define LTDE_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("line table delta encoder: assertion failed");

// Next-cycle implication, off while reset is asserted.
`define LTDE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("line table delta encoder: assertion failed");

`endif

### hdl/ltde_pkg.sv
// Shared types and constants of the line table delta encoder.
// No dependencies; imported by ltde_special and the top level.
`default_nettype none

package ltde_pkg;

	localparam int DELTA_W = 32;
	localparam int BYTE_W  = 8;
	localparam int DIGIT_W = 7;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_LO   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OP_FIRST = 2'd2;

	// register reset values
	localparam logic [BYTE_W-1:0] WIN_LO_RST   = 8'hFF;
	localparam logic [BYTE_W-1:0] WIN_LEN_RST  = 8'd4;
	localparam logic [BYTE_W-1:0] OP_FIRST_RST = 8'd5;

	// standard opcodes
	localparam logic [BYTE_W-1:0] OP_COPY       = 8'h01;
	localparam logic [BYTE_W-1:0] OP_ADVANCE_PC = 8'h02;
	localparam logic [BYTE_W-1:0] OP_ADVANCE_LN = 8'h03;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SPECIAL,
		ST_PC_OP,
		ST_PC_LEB,
		ST_LN_OP,
		ST_LN_LEB,
		ST_COPY
	} state_t;

	// verdict of the special opcode check
	typedef struct packed {
		logic              valid;
		logic              hit;
		logic [BYTE_W-1:0] opcode;
	} spec_res_t;

endpackage

`default_nettype wire

### hdl/ltde_special.sv
// Two-stage special opcode check of the line table delta encoder.
// Depends on ltde_pkg.
`default_nettype none

module ltde_special
	import ltde_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [DELTA_W-1:0] address_delta,
	input  wire logic [DELTA_W-1:0] line_delta,
	input  wire logic [BYTE_W-1:0]  win_lo,
	input  wire logic [BYTE_W-1:0]  win_len,
	input  wire logic [BYTE_W-1:0]  op_first,
	output spec_res_t               res
);

	logic                valid_s1;
	logic [DELTA_W:0]    diff_s1;
	logic                ad_ok_s1;
	logic [2*BYTE_W-1:0] prod_s1;

	logic                valid_s2;
	logic                hit_s2;
	logic [BYTE_W-1:0]   opcode_s2;

	logic [2*BYTE_W:0]   sum;
	logic                in_win;

	// A special opcode needs 0 <= address_delta <= 255, so an 8x8 product suffices.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			diff_s1  <= {line_delta[DELTA_W-1], line_delta}
				- {{(DELTA_W+1-BYTE_W){win_lo[BYTE_W-1]}}, win_lo};
			ad_ok_s1 <= (address_delta[DELTA_W-1:BYTE_W] == '0);
			prod_s1  <= (2*BYTE_W)'(win_len) * (2*BYTE_W)'(address_delta[BYTE_W-1:0]);
		end
	end

	assign in_win = (diff_s1[DELTA_W:BYTE_W] == '0) && (diff_s1[BYTE_W-1:0] < win_len);
	assign sum    = (2*BYTE_W+1)'(op_first) + (2*BYTE_W+1)'(diff_s1[BYTE_W-1:0])
		+ (2*BYTE_W+1)'(prod_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// All terms are non-negative, so the lower bound at op_first always holds.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			hit_s2    <= in_win && ad_ok_s1 && (sum[2*BYTE_W:BYTE_W] == '0);
			opcode_s2 <= sum[BYTE_W-1:0];
		end
	end

	assign res = '{valid: valid_s2, hit: hit_s2, opcode: opcode_s2};

endmodule

`default_nettype wire

### hdl/line_table_delta_encoder.sv
// Top level of the line table delta encoder: config registers, byte sequencer, output register.
// Depends on ltde_pkg and ltde_special.
//
//  channel  | direction | handshake                  | word
//  ---------+-----------+----------------------------+--------------------------------------
//  s_axis   | in        | s_axis_tvalid/s_axis_tready | address_delta, line_delta (64 bits)
//  m_axis   | out       | m_axis_tvalid/m_axis_tready | out_byte in tdata, last in tlast
//  cfg      | in        | cfg_valid/cfg_ready         | cfg_index selects, cfg_data is value
//
// The special opcode check decides between the special opcode and the long form; then the
// sequencer emits one byte per cycle while m_axis is not stalled, 1 to 13 bytes per item.
// The byte sequencer is the limit: it shifts the signed LEB128 values out one 7-bit group
// per cycle unless m_axis stalls, and takes a new item only when back in idle.
// The output register holds the last byte of an item while the next item is accepted.
// A stalled m_axis freezes the sequencer; no byte is lost or repeated.
// Reset clears the registers to window low -1, window length 4, first special opcode 5 and
// empties the output; cfg_ready is always high.
`default_nettype none

module line_table_delta_encoder
	import ltde_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// input word
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [2*DELTA_W-1:0]   s_axis_tdata,   // [31:0] address_delta, [63:32] line_delta
	// output word
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [BYTE_W-1:0]           m_axis_tdata,   // [7:0] out_byte
	output logic                        m_axis_tlast,   // last
	// configuration writes
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [BYTE_W-1:0]      cfg_data
);

	logic [BYTE_W-1:0]  win_lo_q;
	logic [BYTE_W-1:0]  win_len_q;
	logic [BYTE_W-1:0]  op_first_q;

	state_t             state_q;
	state_t             state_d;

	logic [DELTA_W-1:0] ad_q;
	logic [DELTA_W-1:0] ld_q;
	logic [DELTA_W-1:0] val_q;

	logic               m_valid_q;
	logic [BYTE_W-1:0]  m_data_q;
	logic               m_last_q;

	logic               in_accept;
	logic               out_free;
	logic               leb_end;
	logic [BYTE_W-1:0]  leb_byte;
	spec_res_t          spec;

	logic               emit;
	logic [BYTE_W-1:0]  emit_byte;
	logic               emit_last;
	logic               load_ad;
	logic               load_ld;
	logic               shift;

	assign cfg_ready     = 1'b1;
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	// the sequencer may write the output register when it is empty or being drained
	assign out_free      = !m_valid_q || m_axis_tready;

	// config registers; writes to an index beyond the list drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_lo_q   <= WIN_LO_RST;
			win_len_q  <= WIN_LEN_RST;
			op_first_q <= OP_FIRST_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WIN_LO:   win_lo_q   <= cfg_data;
				CFG_WIN_LEN:  win_len_q  <= cfg_data;
				CFG_OP_FIRST: op_first_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ltde_special u_special (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (in_accept),
		.address_delta (s_axis_tdata[DELTA_W-1:0]),
		.line_delta    (s_axis_tdata[2*DELTA_W-1:DELTA_W]),
		.win_lo        (win_lo_q),
		.win_len       (win_len_q),
		.op_first      (op_first_q),
		.res           (spec)
	);

	// Signed LEB128, one 7-bit group per cycle while the output is free. The group is final when everything from
	// its sign bit up is all zeros or all ones; continuation bit set otherwise.
	assign leb_end  = (val_q[DELTA_W-1:DIGIT_W-1] == '0) || (val_q[DELTA_W-1:DIGIT_W-1] == '1);
	assign leb_byte = {~leb_end, val_q[DIGIT_W-1:0]};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (spec.valid) begin
					if (spec.hit) state_d = ST_SPECIAL;
					else if (ad_q != '0) state_d = ST_PC_OP;
					else state_d = ST_LN_OP;
				end
			end
			ST_SPECIAL: begin
				if (out_free) state_d = ST_IDLE;
			end
			ST_PC_OP: begin
				if (out_free) state_d = ST_PC_LEB;
			end
			ST_PC_LEB: begin
				if (out_free && leb_end) state_d = ST_LN_OP;
			end
			ST_LN_OP: begin
				if (out_free) state_d = ST_LN_LEB;
			end
			ST_LN_LEB: begin
				if (out_free && leb_end) state_d = ST_COPY;
			end
			ST_COPY: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		emit      = 1'b0;
		emit_byte = '0;
		emit_last = 1'b0;
		load_ad   = 1'b0;
		load_ld   = 1'b0;
		shift     = 1'b0;
		unique case (state_q)
			ST_SPECIAL: begin
				emit      = out_free;
				emit_byte = spec.opcode;
				emit_last = 1'b1;
			end
			ST_PC_OP: begin
				emit      = out_free;
				emit_byte = OP_ADVANCE_PC;
				load_ad   = out_free;
			end
			ST_PC_LEB, ST_LN_LEB: begin
				emit      = out_free;
				emit_byte = leb_byte;
				shift     = out_free;
			end
			ST_LN_OP: begin
				emit      = out_free;
				emit_byte = OP_ADVANCE_LN;
				load_ld   = out_free;
			end
			ST_COPY: begin
				emit      = out_free;
				emit_byte = OP_COPY;
				emit_last = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// hold the deltas for the long form; the shift register works on a copy
	always_ff @(posedge clk) begin
		if (in_accept) begin
			ad_q <= s_axis_tdata[DELTA_W-1:0];
			ld_q <= s_axis_tdata[2*DELTA_W-1:DELTA_W];
		end
		if (load_ad) begin
			val_q <= ad_q;
		end else if (load_ld) begin
			val_q <= ld_q;
		end else if (shift) begin
			// arithmetic shift right by one group
			val_q <= {{DIGIT_W{val_q[DELTA_W-1]}}, val_q[DELTA_W-1:DIGIT_W]};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_data_q <= emit_byte;
			m_last_q <= emit_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

endmodule

`default_nettype wire

### hdl/ltde_checker.sv
// Port-level checker of the line table delta encoder, bound to the top level.
// Depends on line_table_delta_encoder_assert.svh.
`default_nettype none

`include "line_table_delta_encoder_assert.svh"

module ltde_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [7:0]  m_axis_tdata,
	input wire logic        m_axis_tlast,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready
);

	// one item at a time: an accepted word closes the input
	`LTDE_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)

	// a run has no bubbles: after a non-final byte the next one is ready
	`LTDE_ASSERT_NEXT(a_run_dense, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid)

	// a stalled output word stays and holds its payload
	`LTDE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

	// configuration is always taken
	`LTDE_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind line_table_delta_encoder ltde_checker u_ltde_checker (.*);

`default_nettype wire
